@@ rtl/core/sfd_pkg.sv @@
// Shared types and constants for the SLIP frame decoder.
// No dependencies; imported by sfd_decoder and slip_frame_decoder.
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEsc = 8'hDD;
  localparam logic [7:0] SlipEscEnd = 8'hDC;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  // Framing state carried from one byte to the next.
  typedef struct packed {
    logic in_frame;
    logic escape_pending;
    logic dropping;
    logic has_bytes;
  } frame_state_t;

  // Result of decoding one byte: emit is set when a result item follows.
  typedef struct packed {
    logic       emit;
    kind_e      kind;
    logic [7:0] data;
  } result_t;

endpackage : sfd_pkg

`default_nettype wire

@@ rtl/core/sfd_decoder.sv @@
// Framing state registers and per-byte SLIP decode logic.
// Depends on sfd_pkg.
`default_nettype none

module sfd_decoder import sfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] byte_i,
  input  wire logic       take_i,
  output result_t         res_o
);

  frame_state_t state_q, state_d;
  result_t      res;

  always_comb begin
    state_d = state_q;
    res     = '{emit: 1'b0, kind: KIND_DATA, data: 8'h00};
    if (state_q.escape_pending && state_q.in_frame) begin
      state_d.escape_pending = 1'b0;
      if (byte_i == SlipEscEsc || byte_i == SlipEscEnd) begin
        if (!state_q.dropping) begin
          state_d.has_bytes = 1'b1;
          res.emit = 1'b1;
          res.data = (byte_i == SlipEscEsc) ? SlipEsc : SlipEnd;
        end
      end else begin
        // Bad escape: consume the byte and discard the frame.
        state_d.dropping = 1'b1;
      end
    end else if (byte_i == SlipEnd) begin
      if (state_q.in_frame && state_q.has_bytes) begin
        res.emit = 1'b1;
        res.kind = state_q.dropping ? KIND_DROP : KIND_GOOD;
      end
      state_d.in_frame       = !state_q.in_frame;
      state_d.escape_pending = 1'b0;
      state_d.dropping       = 1'b0;
      state_d.has_bytes      = 1'b0;
    end else if (byte_i == SlipEsc) begin
      if (state_q.in_frame) state_d.escape_pending = 1'b1;
    end else if (state_q.in_frame && !state_q.dropping) begin
      state_d.has_bytes = 1'b1;
      res.emit = 1'b1;
      res.data = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (take_i) begin
      state_q <= state_d;
    end
  end

  assign res_o = res;

endmodule : sfd_decoder

`default_nettype wire

@@ rtl/core/slip_frame_decoder.sv @@
// SLIP frame decoder top level: input register, decoder, result register.
// Depends on sfd_pkg and sfd_decoder.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_byte_i) takes one raw byte of
//   the SLIP stream per request. Output channel (out_valid_o / out_ready_i)
//   delivers zero or one result per byte: kind_o = data with the decoded
//   byte on data_byte_o, or a good/drop marker at a closing END with
//   data_byte_o at zero. Empty frames and out-of-frame bytes give nothing.
// Path: an accepted byte is held in the input register, decoded
//   combinationally, and its result is loaded into the result register,
//   which drives out_valid_o, kind_o and data_byte_o until it is taken.
// Throughput: one byte per cycle when not stalled, set by the single decode
//   stage between input and result registers; framing flags update that cycle.
// Stall: while the result register holds an untaken request, a byte that
//   would produce a result waits in the input register; bytes that produce
//   nothing still drain. in_ready_o drops only when both registers are full.
// Reset: asynchronous, active low; clears both valid flags and the framing
//   state, so the decoder starts outside any frame.
`default_nettype none

module slip_frame_decoder import sfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  kind_e      out_kind_q;
  logic [7:0] out_data_q;

  result_t    res;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  // Advance the input register when its byte gives nothing, or when the
  // result register is free to take what it gives.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!res.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;

  sfd_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (s1_byte_q),
    .take_i (s1_adv),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_byte_q <= in_byte_i;
  end

  // Result register: load on a result, drop the valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res.emit) begin
      out_kind_q <= res.kind;
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign data_byte_o = out_data_q;

  // A result leaving the decoder always lands in the result register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res.emit) |=> out_valid_q)
    else $error("decoded result not captured");

  // The input side stalls only when both registers are full and blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

  // Markers carry a zero data byte.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KIND_DATA) |-> (out_data_q == 8'h00))
    else $error("marker with nonzero data byte");

  // A stalled result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(s1_adv && res.emit))
    else $error("result register overwritten while stalled");

endmodule : slip_frame_decoder

`default_nettype wire

@@ test/slip_frame_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for slip_frame_decoder: watches both request channels, predicts
// the result of each accepted byte and compares it. Depends on sfd_pkg.
module slip_frame_checker
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  output int         error_count_o,
  output int         pending_o,
  output int         data_count_o,
  output int         good_count_o,
  output int         drop_count_o
);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } slip_result_t;

  slip_result_t expected_q[$];

  // Framing state as seen by the predictor.
  logic in_frame;
  logic esc_armed;
  logic discarding;
  logic emitted_any;

  // Append one predicted result at the tail of the queue.
  task automatic queue_expected(input slip_result_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  // Advance the framing state by one raw byte; queue the result it causes.
  task automatic decode_byte(input logic [7:0] raw);
    slip_result_t res;
    if (esc_armed && in_frame) begin
      esc_armed = 1'b0;
      if (raw != SlipEscEsc && raw != SlipEscEnd) begin
        discarding = 1'b1;
      end else if (!discarding) begin
        emitted_any = 1'b1;
        res.kind = KIND_DATA;
        res.data = (raw == SlipEscEsc) ? SlipEsc : SlipEnd;
        queue_expected(res);
      end
    end else if (raw == SlipEnd) begin
      if (in_frame && emitted_any) begin
        res.kind = discarding ? KIND_DROP : KIND_GOOD;
        res.data = 8'h00;
        queue_expected(res);
      end
      in_frame    = !in_frame;
      discarding  = 1'b0;
      emitted_any = 1'b0;
      esc_armed   = 1'b0;
    end else if (raw == SlipEsc) begin
      if (in_frame) esc_armed = 1'b1;
    end else if (in_frame && !discarding) begin
      emitted_any = 1'b1;
      res.kind = KIND_DATA;
      res.data = raw;
      queue_expected(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slip_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      in_frame      = 1'b0;
      esc_armed     = 1'b0;
      discarding    = 1'b0;
      emitted_any   = 1'b0;
      error_count_o = 0;
      pending_o     = 0;
      data_count_o  = 0;
      good_count_o  = 0;
      drop_count_o  = 0;
    end else begin
      // Check the delivered request first: it never belongs to a byte taken now.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (error_count_o < 10)
            $display("%0t: unexpected result kind=%0d data=%02h",
                     $realtime, kind_i, data_byte_i);
          error_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (kind_i !== want.kind || data_byte_i !== want.data) begin
            if (error_count_o < 10)
              $display("%0t: mismatch: expected kind=%0d data=%02h, got kind=%0d data=%02h",
                       $realtime, want.kind, want.data, kind_i, data_byte_i);
            error_count_o++;
          end
        end
        if (kind_i == KIND_DATA) data_count_o++;
        else if (kind_i == KIND_GOOD) good_count_o++;
        else if (kind_i == KIND_DROP) drop_count_o++;
      end
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i);
      pending_o = expected_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Top of the SLIP frame decoder testbench: clock, reset, byte stimulus and
// verdict. Depends on sfd_pkg, slip_frame_decoder and slip_frame_checker.
module tb;
  import sfd_pkg::*;

  localparam int ResetCycles    = 6;
  localparam int TailCycles     = 10;
  localparam int LongHoldCycles = 60;
  localparam int PhaseItems     = 240;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;

  int error_count;
  int open_requests;
  int data_count;
  int good_count;
  int drop_count;

  // Idling knobs, written only by the stimulus process.
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;

  // Receiver-side bookkeeping for the long hold-off.
  int hold_ack  = 0;
  int hold_left = 0;

  int items_sent   = 0;
  int ignored_sent = 0;

  always #6 clk = ~clk;

  slip_frame_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_byte_i  (in_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .kind_o     (kind),
    .data_byte_o(data_byte)
  );

  slip_frame_checker u_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .kind_i       (kind),
    .data_byte_i  (data_byte),
    .error_count_o(error_count),
    .pending_o    (open_requests),
    .data_count_o (data_count),
    .good_count_o (good_count),
    .drop_count_o (drop_count)
  );

  // Receiver: stall at random, or hold off for a long stretch when the
  // stimulus asks for one. The hold-off counts its own cycles here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_ready <= 1'b0;
      hold_ack  <= hold_req;
      hold_left <= LongHoldCycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one byte as a request and hold it until the block takes it.
  // Enter and leave at a falling edge; valid is written once per edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Put one payload byte on the wire, escaping END and ESC.
  task automatic send_payload(input logic [7:0] p);
    if (p == SlipEnd) begin
      send_byte(SlipEsc);
      send_byte(SlipEscEnd);
    end else if (p == SlipEsc) begin
      send_byte(SlipEsc);
      send_byte(SlipEscEsc);
    end else begin
      send_byte(p);
    end
  endtask

  // Bias payloads toward the framing codes so escapes show up often.
  function automatic logic [7:0] pick_payload();
    logic [7:0] v;
    case ($urandom_range(7))
      0:       v = SlipEnd;
      1:       v = SlipEsc;
      2:       v = $urandom_range(1) ? SlipEscEsc : SlipEscEnd;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Mostly well-formed frames with random content; some carry a bad escape
  // or lose their closing END, which knocks the framing out of step.
  task automatic send_random_frame();
    int         len;
    int         flaw;
    logic [7:0] code;
    len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    flaw = $urandom_range(99);
    send_byte(SlipEnd);
    for (int i = 0; i < len; i++) begin
      if (flaw < 10 && i == len / 2) begin
        code = 8'($urandom_range(255));
        while (code == SlipEscEsc || code == SlipEscEnd) code = 8'($urandom_range(255));
        send_byte(SlipEsc);
        send_byte(code);
      end
      send_payload(pick_payload());
    end
    if (flaw < 10 || flaw >= 14) send_byte(SlipEnd);
    // Drop in some line noise between frames now and then.
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(8'($urandom_range(255)));
        ignored_sent++;
      end
    end
  endtask

  // Withdraw the request and wait until every expected result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (open_requests != 0) @(negedge clk);
  endtask

  initial begin
    int phase_base;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bytes outside a frame: ignored.
    send_byte(8'h00);
    send_byte(SlipEsc);
    // Empty frame: nothing.
    send_byte(SlipEnd);
    send_byte(SlipEnd);
    // Good frame with both escapes and extreme data values.
    send_byte(SlipEnd);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SlipEsc);
    send_byte(SlipEscEsc);
    send_byte(SlipEsc);
    send_byte(SlipEscEnd);
    send_byte(SlipEnd);
    // Bad escape after a byte went out; while discarding, ESC still arms and
    // eats the END that follows, so the second END closes with a drop marker.
    send_byte(SlipEnd);
    send_byte(8'h55);
    send_byte(SlipEsc);
    send_byte(8'h41);
    send_byte(SlipEsc);
    send_byte(SlipEnd);
    send_byte(SlipEnd);
    // ESC followed by ESC before any byte: discarded empty frame, no marker.
    send_byte(SlipEnd);
    send_byte(SlipEsc);
    send_byte(SlipEsc);
    send_byte(8'h01);
    send_byte(SlipEnd);

    // Long receiver hold-off while a long frame keeps coming: fill the block
    // until it stalls its input, then pause until every result is back.
    hold_req++;
    send_byte(SlipEnd);
    repeat (20) send_byte(8'($urandom_range(191, 1)));
    send_byte(SlipEnd);
    drain_results();

    // Random part over four idling mixes, the first with no idling at all.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      phase_base = items_sent - ignored_sent;
      while (items_sent - ignored_sent - phase_base < PhaseItems) send_random_frame();
      drain_results();
    end

    drain_results();
    repeat (TailCycles) @(negedge clk);

    $display("Sent %0d bytes (%0d line noise) under four idling mixes and a long hold-off.",
             items_sent, ignored_sent);
    $display("Checked %0d data bytes, %0d good-frame and %0d dropped-frame markers.",
             data_count, good_count, drop_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
